### hdl/stepper_driver_uart_datagram_codec_core_macros.svh
// Assertion macros for the datagram codec core.
// Depends on nothing; files that assert take it by include.
`ifndef STEPPER_DRIVER_UART_DATAGRAM_CODEC_CORE_MACROS_SVH
`define STEPPER_DRIVER_UART_DATAGRAM_CODEC_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge out of reset.
`define SDC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDC_ASSERT_CLK(lbl, prop, msg)
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/sdc_pkg.sv
// Shared types, codes, constants and helper functions of the datagram codec.
// No dependencies.
package sdc_pkg;

	// input actions
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_REPLY = 2'd2;

	// result kinds and read status codes
	localparam logic       KIND_TX     = 1'b0;
	localparam logic       KIND_RESULT = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_BADLEN   = 2'd2;

	// datagram constants
	localparam logic [7:0] SYNC_REQ   = 8'hF5;
	localparam logic [7:0] SYNC_RPL   = 8'h05;
	localparam logic [7:0] ADDR_RPL   = 8'hFF;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [3:0] REPLY_LEN  = 4'd10;
	localparam logic [3:0] READ_LEN   = 4'd5;
	localparam logic [3:0] WRITE_LEN  = 4'd10;
	localparam logic [3:0] READ_CRC_N = 4'd3;
	localparam logic [3:0] FULL_CRC_N = 4'd7;
	localparam logic [3:0] CNT_MAX    = 4'd15;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_DECODE
	} cmd_kind_t;

	// one queued job; rbuf holds reply byte i at bits [8i+7:8i]
	typedef struct packed {
		cmd_kind_t   kind;
		logic        len_ok;
		logic [7:0]  node;
		logic [6:0]  reg_addr;
		logic [31:0] wval;
		logic [79:0] rbuf;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	// one byte of CRC8, data taken LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] b;
		logic       fb;
		c = crc;
		b = data;
		for (int k = 0; k < 8; k++) begin
			fb = c[7] ^ b[0];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
			b = {1'b0, b[7:1]};
		end
		return c;
	endfunction

	// four bytes {b3,b2,b1,b0} framed with start/stop bits, packed LSB first
	function automatic logic [39:0] pack4(input logic [31:0] b);
		return {1'b1, b[31:24], 1'b0, 1'b1, b[23:16], 1'b0,
			1'b1, b[15:8], 1'b0, 1'b1, b[7:0], 1'b0};
	endfunction

endpackage

### hdl/sdc_ifs.sv
// Request and response channel interfaces of the datagram codec.
// Depends on nothing but plain logic types.
interface sdc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  node_addr;
	logic [6:0]  reg_addr;
	logic [31:0] write_value;
	logic [7:0]  reply_byte;
	logic        reply_last;

	modport source (output valid, action, node_addr, reg_addr, write_value,
		reply_byte, reply_last, input ready);
	modport sink (input valid, action, node_addr, reg_addr, write_value,
		reply_byte, reply_last, output ready);
endinterface

interface sdc_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [31:0] read_value;
	logic [1:0]  read_status;

	modport source (output valid, result_kind, out_byte, out_last, read_value,
		read_status, input ready);
	modport sink (input valid, result_kind, out_byte, out_last, read_value,
		read_status, output ready);
endinterface

### hdl/stepper_driver_uart_datagram_codec_core.sv
// Top level of the single-wire stepper-driver UART datagram codec.
// Depends on sdc_pkg, sdc_ifs, sdc_front, sdc_fifo, sdc_back and the macro header.
//
// Usage:
//  req  (sink)   : one word per action - read request, write request or reply byte.
//  rsp  (source) : transmit bytes (result_kind 0) and decode results (result_kind 1).
//  A read request yields 5 line bytes, a write request 10, both with out_last on the
//  final byte. Reply bytes are stored until the one flagged reply_last; that word
//  yields one decode result (value, status) with out_last set.
// Timing:
//  A request's first byte reaches rsp through the queue, the back end's job register
//  and the output register. The back end pops a job only when idle, then walks its
//  line bytes in turn. A full reply check walks all ten bytes against the re-encoded
//  datagram before its result; a reply of the wrong length skips the walk. Non-final
//  reply bytes queue no job. The CRC is folded in one byte per cycle alongside the
//  byte walk; a stall on rsp holds both.
// Reset clears the queue, the reply byte count, the back end's busy flag and the output valid.
// A stall on rsp holds the output register and the back end; the queue
// (QueueDepth jobs) keeps req open until it fills.
`include "stepper_driver_uart_datagram_codec_core_macros.svh"

module stepper_driver_uart_datagram_codec_core #(
	parameter int QueueDepth = sdc_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sdc_req_if.sink   req,
	sdc_rsp_if.source rsp
);
	import sdc_pkg::*;

	push_t push;
	cmd_t  head;
	logic  q_full;
	logic  q_empty;
	logic  pop;
	logic  rsp_result;
	logic  result_ok;
	logic  rsp_mism;
	logic  mism_ok;

	// front: classify words, gather reply bytes, queue jobs
	sdc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.push   (push)
	);

	// job queue decoupling the two halves
	sdc_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: byte sequencer, CRC and reply check, registered output
	sdc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.rsp     (rsp)
	);

	assign rsp_result = rsp.valid && (rsp.result_kind == KIND_RESULT);
	assign result_ok  = rsp.out_last && (rsp.out_byte == 8'h00);
	assign rsp_mism   = rsp.valid && (rsp.read_status == ST_MISMATCH);
	assign mism_ok    = (rsp.read_value == 32'hFFFF_FFFF);

	// a full queue must close the request channel
	`SDC_ASSERT_CLK(a_full_blocks, q_full |-> !req.ready, "request accepted into a full queue")
	// a job pushed into an empty queue is visible next cycle
	`SDC_ASSERT_NEXT(a_push_lands, push.valid && q_empty, !q_empty, "pushed job lost")
	// decode results always close the item and carry no line byte
	`SDC_ASSERT_CLK(a_result_form, rsp_result |-> result_ok, "malformed decode result")
	// mismatch always reports all ones
	`SDC_ASSERT_CLK(a_mismatch_val, rsp_mism |-> mism_ok, "mismatch with wrong value")

endmodule

### hdl/sdc_front.sv
// Front end: accepts words, collects reply bytes and queues jobs.
// Depends on sdc_pkg and sdc_req_if.
module sdc_front (
	input  logic          clk,
	input  logic          arst_n,
	sdc_req_if.sink       req,
	input  logic          q_full,
	output sdc_pkg::push_t push
);
	import sdc_pkg::*;

	logic [3:0]  cnt_q;
	logic [7:0]  buf_q [10];
	logic        accept;
	logic        is_reply;
	logic [79:0] snap;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign is_reply  = (req.action == ACT_REPLY);

	// buffer as it stands once this byte is stored
	always_comb begin
		for (int i = 0; i < 10; i++) begin
			snap[8*i +: 8] = (cnt_q == 4'(i)) ? req.reply_byte : buf_q[i];
		end
	end

	always_comb begin
		push.valid = accept && ((req.action == ACT_READ) || (req.action == ACT_WRITE) ||
			(is_reply && req.reply_last));
		unique case (req.action)
			ACT_READ:  push.cmd.kind = CMD_READ;
			ACT_WRITE: push.cmd.kind = CMD_WRITE;
			default:   push.cmd.kind = CMD_DECODE;
		endcase
		push.cmd.len_ok   = (cnt_q == REPLY_LEN - 4'd1);
		push.cmd.node     = req.node_addr;
		push.cmd.reg_addr = req.reg_addr;
		push.cmd.wval     = req.write_value;
		push.cmd.rbuf     = snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_reply) begin
			if (req.reply_last) begin
				cnt_q <= '0;
			end else if (cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// bytes past the tenth are dropped
	always_ff @(posedge clk) begin
		if (accept && is_reply && (cnt_q < REPLY_LEN)) begin
			buf_q[cnt_q] <= req.reply_byte;
		end
	end

endmodule

### hdl/sdc_fifo.sv
// Short job queue between front and back end.
// Depends on sdc_pkg.
module sdc_fifo #(
	parameter int Depth = sdc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sdc_pkg::push_t push,
	input  logic           pop,
	output sdc_pkg::cmd_t  head,
	output logic           full,
	output logic           empty
);
	import sdc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == DepthC);
	assign empty   = (cnt_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.cmd;
		end
	end

endmodule

### hdl/sdc_back.sv
// Back end: builds datagrams byte by byte, runs the CRC and checks replies.
// Depends on sdc_pkg and sdc_rsp_if.
module sdc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sdc_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	sdc_rsp_if.source     rsp
);
	import sdc_pkg::*;

	cmd_t        cmd_q;
	logic        busy_q;
	logic [3:0]  idx_q;
	logic [7:0]  crc_q;
	logic        mism_q;
	logic        vld_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] val_q;
	logic [1:0]  stat_q;

	logic [7:0]  m [8];
	logic [79:0] line;
	logic [7:0]  line_b [10];
	logic [7:0]  rx_b [10];
	logic [7:0]  line_sel;
	logic [7:0]  rx_sel;
	logic [7:0]  m_sel;
	logic [31:0] dval;
	logic [3:0]  crc_n;
	logic [3:0]  tx_len;
	logic        absorb;
	logic        adv;

	assign pop = !busy_q && !q_empty;
	assign adv = !vld_q || rsp.ready;

	// value bytes sit in symbols 3..6 of the received reply
	assign dval = {cmd_q.rbuf[38:31], cmd_q.rbuf[48:41], cmd_q.rbuf[58:51],
		cmd_q.rbuf[68:61]};

	always_comb begin
		unique case (cmd_q.kind)
			CMD_READ: begin
				m[0] = SYNC_REQ;
				m[1] = cmd_q.node;
				m[2] = {1'b0, cmd_q.reg_addr};
				m[3] = crc_q;
				m[4] = '0;
				m[5] = '0;
				m[6] = '0;
				m[7] = '0;
			end
			CMD_WRITE: begin
				m[0] = SYNC_REQ;
				m[1] = cmd_q.node;
				m[2] = {1'b1, cmd_q.reg_addr};
				m[3] = cmd_q.wval[31:24];
				m[4] = cmd_q.wval[23:16];
				m[5] = cmd_q.wval[15:8];
				m[6] = cmd_q.wval[7:0];
				m[7] = crc_q;
			end
			default: begin
				m[0] = SYNC_RPL;
				m[1] = ADDR_RPL;
				m[2] = {1'b0, cmd_q.reg_addr};
				m[3] = dval[31:24];
				m[4] = dval[23:16];
				m[5] = dval[15:8];
				m[6] = dval[7:0];
				m[7] = crc_q;
			end
		endcase
	end

	assign line = {pack4({m[7], m[6], m[5], m[4]}), pack4({m[3], m[2], m[1], m[0]})};

	always_comb begin
		for (int i = 0; i < 10; i++) begin
			line_b[i] = line[8*i +: 8];
			rx_b[i]   = cmd_q.rbuf[8*i +: 8];
		end
	end

	assign line_sel = (idx_q < REPLY_LEN) ? line_b[idx_q] : '0;
	assign rx_sel   = (idx_q < REPLY_LEN) ? rx_b[idx_q] : '0;
	assign m_sel    = m[idx_q[2:0]];
	assign crc_n    = (cmd_q.kind == CMD_READ) ? READ_CRC_N : FULL_CRC_N;
	assign tx_len   = (cmd_q.kind == CMD_READ) ? READ_LEN : WRITE_LEN;
	// crc_q holds the CRC over m[0..idx-1] while idx is below crc_n
	assign absorb   = (idx_q < crc_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && adv) begin
				unique case (cmd_q.kind)
					CMD_READ, CMD_WRITE: begin
						vld_q <= 1'b1;
						if (idx_q == tx_len - 4'd1) begin
							busy_q <= 1'b0;
						end
					end
					default: begin
						if (!cmd_q.len_ok || (idx_q == REPLY_LEN)) begin
							vld_q  <= 1'b1;
							busy_q <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			idx_q  <= '0;
			crc_q  <= '0;
			mism_q <= 1'b0;
		end else if (busy_q && adv) begin
			if (absorb) begin
				crc_q <= crc8_byte(crc_q, m_sel);
			end
			unique case (cmd_q.kind)
				CMD_READ, CMD_WRITE: begin
					idx_q  <= idx_q + 4'd1;
					kind_q <= KIND_TX;
					byte_q <= line_sel;
					last_q <= (idx_q == tx_len - 4'd1);
					val_q  <= '0;
					stat_q <= ST_OK;
				end
				default: begin
					kind_q <= KIND_RESULT;
					byte_q <= '0;
					last_q <= 1'b1;
					if (!cmd_q.len_ok) begin
						val_q  <= '0;
						stat_q <= ST_BADLEN;
					end else if (idx_q == REPLY_LEN) begin
						val_q  <= mism_q ? '1 : dval;
						stat_q <= mism_q ? ST_MISMATCH : ST_OK;
					end else begin
						idx_q  <= idx_q + 4'd1;
						mism_q <= mism_q | (line_sel != rx_sel);
					end
				end
			endcase
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.result_kind = kind_q;
	assign rsp.out_byte    = byte_q;
	assign rsp.out_last    = last_q;
	assign rsp.read_value  = val_q;
	assign rsp.read_status = stat_q;

endmodule

### tb/sv/sdc_codec_checker.sv
// Datagram line encoder and the scoreboard that watches the codec's req and rsp channels.
// Depends on sdc_pkg and the channel interfaces in sdc_ifs.
`timescale 1ns / 1ps

package sdc_tb_line_pkg;
	import sdc_pkg::*;

	// CRC8, poly 0x07, zero start, each byte taken LSB first; byte i at msg[8i+:8]
	function automatic logic [7:0] crc8_lsb(input logic [63:0] msg, input int n);
		logic [7:0] crc;
		logic [7:0] b;
		logic       fb;
		crc = 8'h00;
		for (int i = 0; i < n; i++) begin
			b = msg[8*i +: 8];
			for (int k = 0; k < 8; k++) begin
				fb  = crc[7] ^ b[k];
				crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
		end
		return crc;
	endfunction

	// start 0, data, stop 1 per byte; four symbols fill five line bytes
	function automatic logic [79:0] frame_line(input logic [63:0] msg, input int n);
		logic [79:0] dgram;
		logic [39:0] grp;
		dgram = '0;
		for (int g = 0; g < n / 4; g++) begin
			grp = '0;
			for (int s = 0; s < 4; s++)
				grp[10*s +: 10] = {1'b1, msg[8*(4*g + s) +: 8], 1'b0};
			dgram[40*g +: 40] = grp;
		end
		return dgram;
	endfunction

	function automatic logic [79:0] read_line(input logic [7:0] node, input logic [6:0] rg);
		logic [63:0] msg;
		msg = {32'h0, 8'h00, 1'b0, rg, node, SYNC_REQ};
		msg[31:24] = crc8_lsb(msg, 3);
		return frame_line(msg, 4);
	endfunction

	// eight-byte datagram: sync, address, register, value MSB first, CRC
	function automatic logic [79:0] long_line(input logic [7:0] sync, input logic [7:0] addr,
		input logic [7:0] rg, input logic [31:0] val);
		logic [63:0] msg;
		msg = {8'h00, val[7:0], val[15:8], val[23:16], val[31:24], rg, addr, sync};
		msg[63:56] = crc8_lsb(msg, 7);
		return frame_line(msg, 8);
	endfunction
endpackage

module sdc_codec_checker (
	input  logic clk,
	input  logic arst_n,
	sdc_req_if   req,
	sdc_rsp_if   rsp,
	output int   failures,
	output int   pending,
	output int   checked,
	output int   replies_ok,
	output int   replies_bad,
	output int   replies_short
);
	import sdc_pkg::*;
	import sdc_tb_line_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic [31:0] value;
		logic [1:0]  status;
	} rsp_word_t;

	rsp_word_t   owed_q[$];
	rsp_word_t   got;
	rsp_word_t   want;
	logic [79:0] rx_bytes;
	logic [3:0]  rx_count;
	int          fail_n, seen_n, ok_n, bad_n, short_n;

	initial begin
		fail_n  = 0;
		seen_n  = 0;
		ok_n    = 0;
		bad_n   = 0;
		short_n = 0;
	end

	function automatic void owe(input logic kind, input logic [7:0] data, input logic last,
		input logic [31:0] value, input logic [1:0] status);
		rsp_word_t w;
		w.kind   = kind;
		w.data   = data;
		w.last   = last;
		w.value  = value;
		w.status = status;
		owed_q = {owed_q, w};
	endfunction

	function automatic void predict_word(input logic [1:0] act, input logic [7:0] node,
		input logic [6:0] rg, input logic [31:0] val, input logic [7:0] rb, input logic rl);
		logic [79:0] dgram;
		logic [31:0] value;
		logic [1:0]  status;
		case (act)
			ACT_READ: begin
				dgram = read_line(node, rg);
				for (int i = 0; i < 5; i++)
					owe(KIND_TX, dgram[8*i +: 8], i == 4, 32'h0, ST_OK);
			end
			ACT_WRITE: begin
				dgram = long_line(SYNC_REQ, node, {1'b1, rg}, val);
				for (int i = 0; i < 10; i++)
					owe(KIND_TX, dgram[8*i +: 8], i == 9, 32'h0, ST_OK);
			end
			ACT_REPLY: begin
				// bytes past the tenth are dropped, the count sticks at 15
				if (rx_count < REPLY_LEN)
					rx_bytes[8*rx_count +: 8] = rb;
				if (rx_count != CNT_MAX)
					rx_count++;
				if (rl) begin
					if (rx_count != REPLY_LEN) begin
						value  = 32'h0;
						status = ST_BADLEN;
						short_n++;
					end else begin
						// data of symbols 3..6: bits 31, 41, 51, 61 of the line
						value  = {rx_bytes[31 +: 8], rx_bytes[41 +: 8],
							rx_bytes[51 +: 8], rx_bytes[61 +: 8]};
						status = ST_OK;
						if (long_line(SYNC_RPL, ADDR_RPL, {1'b0, rg}, value) != rx_bytes) begin
							value  = 32'hFFFF_FFFF;
							status = ST_MISMATCH;
							bad_n++;
						end else begin
							ok_n++;
						end
					end
					owe(KIND_RESULT, 8'h00, 1'b1, value, status);
					rx_count = 4'd0;
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			rx_bytes = '0;
			rx_count = 4'd0;
		end else begin
			if (req.valid && req.ready)
				predict_word(req.action, req.node_addr, req.reg_addr, req.write_value,
					req.reply_byte, req.reply_last);
			if (rsp.valid && rsp.ready) begin
				got.kind   = rsp.result_kind;
				got.data   = rsp.out_byte;
				got.last   = rsp.out_last;
				got.value  = rsp.read_value;
				got.status = rsp.read_status;
				seen_n++;
				if (owed_q.size() == 0) begin
					fail_n++;
					$display({"%0t: rsp word %0d: expected nothing, got kind %0d byte %02h ",
						"last %0d value %08h status %0d"}, $time, seen_n,
						got.kind, got.data, got.last, got.value, got.status);
				end else begin
					want = owed_q.pop_front();
					if (got !== want) begin
						fail_n++;
						$display({"%0t: rsp word %0d: expected kind %0d byte %02h last %0d ",
							"value %08h status %0d, got kind %0d byte %02h last %0d ",
							"value %08h status %0d"}, $time, seen_n,
							want.kind, want.data, want.last, want.value, want.status,
							got.kind, got.data, got.last, got.value, got.status);
					end
				end
			end
		end
		failures      <= fail_n;
		pending       <= owed_q.size();
		checked       <= seen_n;
		replies_ok    <= ok_n;
		replies_bad   <= bad_n;
		replies_short <= short_n;
	end
endmodule

### tb/sv/tb.sv
// Top of the datagram codec testbench: clock, reset, stimulus, rsp back-pressure, verdict.
// Depends on sdc_pkg, sdc_ifs, the codec core and sdc_codec_checker.
`timescale 1ns / 1ps

module tb;
	import sdc_pkg::*;
	import sdc_tb_line_pkg::*;

	// the one action code the block ignores
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam int WORD_TARGET = 270;
	localparam int HOLD_CYCLES = 400;   // long rsp stall, fills the job queue
	localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake before giving up
	localparam int DRAIN_WAIT  = 30;    // longest job is a full reply check

	typedef enum int {
		FLAW_NONE,
		FLAW_BIT,
		FLAW_REG
	} flaw_t;

	logic clk;
	logic arst_n;

	sdc_req_if req ();
	sdc_rsp_if rsp ();

	int fail_cnt, owed_cnt, seen_cnt, good_cnt, bad_cnt, short_cnt;
	int n_words, n_ignored, burst_left;
	bit hold_go;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	stepper_driver_uart_datagram_codec_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sdc_codec_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.failures      (fail_cnt),
		.pending       (owed_cnt),
		.checked       (seen_cnt),
		.replies_ok    (good_cnt),
		.replies_bad   (bad_cnt),
		.replies_short (short_cnt)
	);

	// Offer one word and wait for it to be taken. The sender runs in bursts;
	// between bursts valid drops for a random gap, sometimes none at all.
	task automatic send(input logic [1:0] act, input logic [7:0] node, input logic [6:0] rg,
		input logic [31:0] val, input logic [7:0] rb, input logic rl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid       <= 1'b1;
		req.action      <= act;
		req.node_addr   <= node;
		req.reg_addr    <= rg;
		req.write_value <= val;
		req.reply_byte  <= rb;
		req.reply_last  <= rl;
		do @(posedge clk); while (!req.ready);
		burst_left--;
		if (act == ACT_NONE)
			n_ignored++;
		else
			n_words++;
	endtask

	task automatic send_request();
		send(($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE, 8'($urandom), 7'($urandom),
			$urandom, 8'($urandom), 1'($urandom));
	endtask

	// Reply of n bytes built from a well-formed datagram; beyond the tenth the
	// bytes are random. A flaw either flips one line bit or changes the register
	// given with the final byte. A request may be slipped in before byte mix_at.
	task automatic send_reply(input logic [6:0] rg, input logic [31:0] val, input int n,
		input flaw_t flaw, input int mix_at);
		logic [79:0] dgram;
		logic [6:0]  rg_end;
		logic [7:0]  b;
		int          pos;
		dgram  = long_line(SYNC_RPL, ADDR_RPL, {1'b0, rg}, val);
		rg_end = rg;
		if (flaw == FLAW_BIT) begin
			pos = $urandom_range(0, 79);
			dgram[pos] = ~dgram[pos];
		end else if (flaw == FLAW_REG) begin
			rg_end = rg ^ 7'($urandom_range(1, 127));
		end
		for (int i = 0; i < n; i++) begin
			if (i == mix_at)
				send_request();
			b = (i < 10) ? dgram[8*i +: 8] : 8'($urandom);
			send(ACT_REPLY, 8'($urandom), (i == n - 1) ? rg_end : 7'($urandom), $urandom,
				b, i == n - 1);
		end
	endtask

	// rsp back-pressure: cycles through always-ready, light, heavy and periodic
	// stall phases; once the random part starts it holds off for a long stretch.
	initial begin
		int cyc;
		bit held;
		cyc  = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			cyc++;
			case ((cyc / 97) % 4)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				2: rsp.ready <= ($urandom_range(0, 9) < 3);
				default: rsp.ready <= ((cyc % 8) < 5);
			endcase
		end
	end

	// watchdog: any handshake on either channel resets the count
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no handshake for %0d cycles, %0d results still owed",
			$time, IDLE_LIMIT, owed_cnt);
		$display("** stepper_driver_uart_datagram_codec_core: FAILED **");
		$finish;
	end

	initial begin
		int          pick;
		int          n;
		logic [31:0] val;
		n_words    = 0;
		n_ignored  = 0;
		burst_left = 0;
		hold_go    = 1'b0;
		req.valid       <= 1'b0;
		req.action      <= ACT_READ;
		req.node_addr   <= 8'h00;
		req.reg_addr    <= 7'h00;
		req.write_value <= 32'h0;
		req.reply_byte  <= 8'h00;
		req.reply_last  <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes of both requests
		send(ACT_READ, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0);
		send(ACT_READ, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send(ACT_WRITE, 8'h00, 7'h00, 32'h0, 8'h00, 1'b0);
		send(ACT_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		// unused action, flagged last, must not close a reply
		send(ACT_NONE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		// lone last byte: wrong length
		send(ACT_REPLY, 8'h00, 7'h00, 32'h0, 8'hA5, 1'b1);
		// clean reply with a request in the middle of it
		send_reply(7'h7F, 32'hFFFF_FFFF, 10, FLAW_NONE, 4);

		// random mix: well-formed replies most often, also broken or wrong-length ones, requests and unused actions
		hold_go = 1'b1;
		while (n_words < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 7))
				0: val = 32'h0;
				1: val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			if (pick < 45) begin
				send_reply(7'($urandom), val, 10, FLAW_NONE,
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : -1);
			end else if (pick < 60) begin
				send_reply(7'($urandom), val, 10, flaw_t'($urandom_range(1, 2)),
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : -1);
			end else if (pick < 72) begin
				// short, over-long, and long enough to saturate the count
				n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 9) : $urandom_range(11, 20);
				send_reply(7'($urandom), val, n, FLAW_NONE,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1);
			end else if (pick < 95) begin
				send_request();
			end else begin
				send(ACT_NONE, 8'($urandom), 7'($urandom), $urandom, 8'($urandom), 1'($urandom));
			end
		end
		req.valid <= 1'b0;

		do @(posedge clk); while (owed_cnt != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d words (%0d more with the unused action), %0d rsp words checked.",
			n_words, n_ignored, seen_cnt);
		$display("Replies closed: %0d good, %0d with bad content, %0d of wrong length.",
			good_cnt, bad_cnt, short_cnt);
		if (fail_cnt == 0 && owed_cnt == 0)
			$display("** stepper_driver_uart_datagram_codec_core: PASSED **");
		else
			$display("** stepper_driver_uart_datagram_codec_core: FAILED **");
		$finish;
	end
endmodule

### files.f
+incdir+hdl
hdl/sdc_pkg.sv
hdl/sdc_ifs.sv
hdl/sdc_front.sv
hdl/sdc_fifo.sv
hdl/sdc_back.sv
hdl/stepper_driver_uart_datagram_codec_core.sv
tb/sv/sdc_codec_checker.sv
tb/sv/tb.sv
